// File: sv/dcde_pkg.sv
// dcde_pkg: shared types and constants of the dma channel descriptor engine
// holds action codes, mode field layout, and controller/datapath structs
// no dependencies
package dcde_pkg;

    // action codes of an input transfer
    localparam logic [1:0] ACT_SETUP  = 2'd0;
    localparam logic [1:0] ACT_STOP   = 2'd1;
    localparam logic [1:0] ACT_VBLANK = 2'd2;
    localparam logic [1:0] ACT_HBLANK = 2'd3;

    // mode half-word layout (control word bits 31:16)
    localparam int MODE_DEST_LSB   = 5;
    localparam int MODE_SRC_LSB    = 7;
    localparam int MODE_REPEAT_BIT = 9;
    localparam int MODE_WIDE_BIT   = 10;
    localparam int MODE_TIM_LSB    = 12;
    localparam int MODE_ENABLE_BIT = 15;

    // timing codes
    localparam logic [1:0] TIM_NOW    = 2'd0;
    localparam logic [1:0] TIM_VBLANK = 2'd1;
    localparam logic [1:0] TIM_HBLANK = 2'd2;

    // address modes
    localparam logic [1:0] AM_INC    = 2'd0;
    localparam logic [1:0] AM_DEC    = 2'd1;
    localparam logic [1:0] AM_FIXED  = 2'd2;
    localparam logic [1:0] AM_RELOAD = 2'd3;

    // unit count when the written count is zero
    localparam logic [16:0] COUNT_ZERO_CH3   = 17'h10000;
    localparam logic [16:0] COUNT_ZERO_OTHER = 17'h04000;
    localparam logic [1:0]  CHAN_LONG_COUNT  = 2'd3;

    // descriptors per blank event at most
    localparam int MAX_RUNS = 4;

    // one input item
    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  channel;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [31:0] control_word;
    } t_req;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic setup;
        logic stop;
        logic scan;
        logic run;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       ch_ok;
        logic       setup_now;
        logic       scan_any;
        logic       out_free;
        logic       run_last;
    } t_status;

endpackage

// File: sv/dcde_in_if.sv
// dcde_in_if: request channel of the dma channel descriptor engine
// valid/ready handshake with action and set-up payload; no dependencies
interface dcde_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  channel;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [31:0] control_word;

    modport source (
        output valid, action, channel, source_address, dest_address, control_word,
        input  ready
    );
    modport sink (
        input  valid, action, channel, source_address, dest_address, control_word,
        output ready
    );
endinterface

// File: sv/dcde_out_if.sv
// dcde_out_if: descriptor channel of the dma channel descriptor engine
// valid/ready handshake with one transfer descriptor; no dependencies
interface dcde_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        run_channel;
    logic [31:0]       run_source;
    logic [31:0]       run_dest;
    logic signed [3:0] source_step;
    logic signed [3:0] dest_step;
    logic [16:0]       unit_count;
    logic              wide_units;
    logic              last_run;

    modport source (
        output valid, run_channel, run_source, run_dest, source_step, dest_step,
               unit_count, wide_units, last_run,
        input  ready
    );
    modport sink (
        input  valid, run_channel, run_source, run_dest, source_step, dest_step,
               unit_count, wide_units, last_run,
        output ready
    );
endinterface

// File: sv/dcde_ctrl.sv
// dcde_ctrl: sequencing state machine of the descriptor engine
// depends on dcde_pkg (t_cmd, t_status, action codes)
module dcde_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dcde_pkg::t_status i_status,
    output dcde_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // requests are taken only in idle
    assign o_ready = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_IDLE;
                case (i_status.action)
                    dcde_pkg::ACT_SETUP: begin
                        if (i_status.ch_ok) begin
                            o_cmd.setup = 1'b1;
                            if (i_status.setup_now) begin
                                n_state = ST_RUN;
                            end
                        end
                    end
                    dcde_pkg::ACT_STOP: begin
                        o_cmd.stop = i_status.ch_ok;
                    end
                    dcde_pkg::ACT_VBLANK, dcde_pkg::ACT_HBLANK: begin
                        o_cmd.scan = 1'b1;
                        if (i_status.scan_any) begin
                            n_state = ST_RUN;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.run = 1'b1;
                    if (i_status.run_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/dcde_datapath.sv
// dcde_datapath: channel registers, start scan, address advance and descriptor register
// depends on dcde_pkg and dcde_out_if
module dcde_datapath #(
    parameter int CHANNELS     = 4,
    parameter int ADDRESS_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dcde_pkg::t_req    i_req,
    input  dcde_pkg::t_cmd    i_cmd,
    output dcde_pkg::t_status o_status,
    dcde_out_if.source        o_desc
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = ADDRESS_BITS;
    localparam int RW = $clog2(dcde_pkg::MAX_RUNS);

    // captured request
    logic [1:0]  r_act;
    logic [1:0]  r_ch;
    logic [31:0] r_saddr;
    logic [31:0] r_daddr;
    logic [31:0] r_ctrl;

    // per-channel state
    logic [AW-1:0]       r_src    [CHANNELS];
    logic [AW-1:0]       r_dst    [CHANNELS];
    logic [AW-1:0]       r_reload [CHANNELS];
    logic [16:0]         r_count  [CHANNELS];
    logic [15:0]         r_mode   [CHANNELS];
    logic [CHANNELS-1:0] r_en;

    // run bookkeeping
    logic [CHANNELS-1:0] r_pending;
    logic [RW-1:0]       r_runs;
    logic                r_immediate;

    // descriptor register
    logic              r_out_valid;
    logic [1:0]        r_o_chan;
    logic [31:0]       r_o_src;
    logic [31:0]       r_o_dst;
    logic signed [3:0] r_o_sstep;
    logic signed [3:0] r_o_dstep;
    logic [16:0]       r_o_count;
    logic              r_o_wide;
    logic              r_o_last;

    logic [3:0]          w_ch4;
    logic                w_ch_ok;
    logic [CW-1:0]       w_idx;
    logic [15:0]         w_new_mode;
    logic [16:0]         w_new_count;
    logic                w_setup_now;
    logic [1:0]          w_timing;
    logic [CHANNELS-1:0] w_match;
    logic [CW-1:0]       w_sel;
    logic [CHANNELS-1:0] w_sel_oh;
    logic                w_last;
    logic [15:0]         w_sel_mode;
    logic                w_wide;
    logic [1:0]          w_sam;
    logic [1:0]          w_dam;
    logic [18:0]         w_delta19;
    logic [AW-1:0]       w_delta;
    logic [AW-1:0]       w_next_src;
    logic [AW-1:0]       w_next_dst;
    logic                w_out_free;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] a, input logic [1:0] am,
                                          input logic [AW-1:0] d);
        logic [AW-1:0] res;
        case (am)
            dcde_pkg::AM_DEC:   res = a - d;
            dcde_pkg::AM_FIXED: res = a;
            default:            res = a + d;
        endcase
        return res;
    endfunction

    function automatic logic signed [3:0] step_of(input logic [1:0] am, input logic wide);
        logic signed [3:0] res;
        case (am)
            dcde_pkg::AM_FIXED: res = 4'sd0;
            dcde_pkg::AM_DEC:   res = wide ? -4'sd4 : -4'sd2;
            default:            res = wide ? 4'sd4 : 4'sd2;
        endcase
        return res;
    endfunction

    // capture request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act   <= i_req.action;
            r_ch    <= i_req.channel;
            r_saddr <= i_req.source_address;
            r_daddr <= i_req.dest_address;
            r_ctrl  <= i_req.control_word;
        end
    end

    // set-up decode
    assign w_ch4       = {2'b00, r_ch};
    assign w_ch_ok     = (w_ch4 < 4'(CHANNELS));
    assign w_idx       = w_ch4[CW-1:0];
    assign w_new_mode  = r_ctrl[31:16];
    assign w_new_count = (r_ctrl[15:0] != 16'h0000) ? {1'b0, r_ctrl[15:0]} :
                         (r_ch == dcde_pkg::CHAN_LONG_COUNT) ? dcde_pkg::COUNT_ZERO_CH3 :
                         dcde_pkg::COUNT_ZERO_OTHER;
    assign w_setup_now = w_new_mode[dcde_pkg::MODE_ENABLE_BIT] &&
                         (w_new_mode[dcde_pkg::MODE_TIM_LSB +: 2] == dcde_pkg::TIM_NOW);

    // blank event match
    assign w_timing = (r_act == dcde_pkg::ACT_VBLANK) ? dcde_pkg::TIM_VBLANK :
                      dcde_pkg::TIM_HBLANK;
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            w_match[i] = r_en[i] && (r_mode[i][dcde_pkg::MODE_TIM_LSB +: 2] == w_timing);
        end
    end

    // lowest pending channel runs next
    always_comb begin
        w_sel = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (r_pending[i]) begin
                w_sel = CW'(i);
            end
        end
    end
    assign w_sel_oh = CHANNELS'(1) << w_sel;
    assign w_last   = (r_runs == RW'(dcde_pkg::MAX_RUNS - 1)) ||
                      ((r_pending & ~w_sel_oh) == '0);

    // address advance of the running channel
    assign w_sel_mode = r_mode[w_sel];
    assign w_wide     = w_sel_mode[dcde_pkg::MODE_WIDE_BIT];
    assign w_sam      = w_sel_mode[dcde_pkg::MODE_SRC_LSB +: 2];
    assign w_dam      = w_sel_mode[dcde_pkg::MODE_DEST_LSB +: 2];
    assign w_delta19  = w_wide ? {r_count[w_sel], 2'b00} : {1'b0, r_count[w_sel], 1'b0};
    assign w_delta    = AW'(w_delta19);
    assign w_next_src = adv(r_src[w_sel], w_sam, w_delta);
    assign w_next_dst = (w_dam == dcde_pkg::AM_RELOAD) ? r_reload[w_sel] :
                        adv(r_dst[w_sel], w_dam, w_delta);

    // channel registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_src[w_idx]    <= AW'(r_saddr);
            r_dst[w_idx]    <= AW'(r_daddr);
            r_reload[w_idx] <= AW'(r_daddr);
            r_count[w_idx]  <= w_new_count;
            r_mode[w_idx]   <= w_new_mode;
        end else if (i_cmd.run) begin
            r_src[w_sel] <= w_next_src;
            r_dst[w_sel] <= w_next_dst;
        end
    end

    // channel enables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '0;
        end else if (i_cmd.setup) begin
            r_en[w_idx] <= w_new_mode[dcde_pkg::MODE_ENABLE_BIT];
        end else if (i_cmd.stop) begin
            r_en[w_idx] <= 1'b0;
        end else if (i_cmd.run) begin
            if (r_immediate || !w_sel_mode[dcde_pkg::MODE_REPEAT_BIT]) begin
                r_en[w_sel] <= 1'b0;
            end
        end
    end

    // pending starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_runs      <= '0;
            r_immediate <= 1'b0;
        end else if (i_cmd.setup) begin
            r_pending   <= w_setup_now ? (CHANNELS'(1) << w_idx) : '0;
            r_runs      <= '0;
            r_immediate <= 1'b1;
        end else if (i_cmd.scan) begin
            r_pending   <= w_match;
            r_runs      <= '0;
            r_immediate <= 1'b0;
        end else if (i_cmd.run) begin
            if (w_last) begin
                r_pending <= '0;
                r_runs    <= '0;
            end else begin
                r_pending <= r_pending & ~w_sel_oh;
                r_runs    <= r_runs + RW'(1);
            end
        end
    end

    // descriptor register
    assign w_out_free = !r_out_valid || o_desc.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.run) begin
            r_out_valid <= 1'b1;
        end else if (o_desc.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run) begin
            r_o_chan  <= 2'(w_sel);
            r_o_src   <= 32'(r_src[w_sel]);
            r_o_dst   <= 32'(r_dst[w_sel]);
            r_o_sstep <= step_of(w_sam, w_wide);
            r_o_dstep <= step_of(w_dam, w_wide);
            r_o_count <= r_count[w_sel];
            r_o_wide  <= w_wide;
            r_o_last  <= w_last;
        end
    end

    assign o_desc.valid       = r_out_valid;
    assign o_desc.run_channel = r_o_chan;
    assign o_desc.run_source  = r_o_src;
    assign o_desc.run_dest    = r_o_dst;
    assign o_desc.source_step = r_o_sstep;
    assign o_desc.dest_step   = r_o_dstep;
    assign o_desc.unit_count  = r_o_count;
    assign o_desc.wide_units  = r_o_wide;
    assign o_desc.last_run    = r_o_last;

    // status to controller
    assign o_status.action    = r_act;
    assign o_status.ch_ok     = w_ch_ok;
    assign o_status.setup_now = w_setup_now;
    assign o_status.scan_any  = (w_match != '0);
    assign o_status.out_free  = w_out_free;
    assign o_status.run_last  = w_last;

    // a descriptor is never loaded over one still waiting
    a_run_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.run |-> w_out_free)
        else $error("descriptor loaded while output register busy");

    // only enabled channels may wait to run
    a_pending_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending & ~r_en) == '0)
        else $error("pending start on a disabled channel");

    // the last descriptor ends the pass
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.run && w_last) |=> (r_pending == '0))
        else $error("pending starts left after last descriptor");

    // a new request finds no start outstanding
    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |-> (r_pending == '0))
        else $error("request taken while starts are pending");

endmodule

// File: sv/dma_channel_descriptor_engine.sv
// dma_channel_descriptor_engine: top level of the four-channel dma descriptor engine
// depends on dcde_pkg, dcde_in_if, dcde_out_if, dcde_ctrl, dcde_datapath
//
//   port     dir   handshake     carries
//   i_req    in    valid/ready   action, channel, source/dest address, control word
//   o_desc   out   valid/ready   one transfer descriptor per channel start
//
// a request is taken in idle and decoded in the next cycle; a stop or a set-up that
// starts nothing then returns to idle, while an immediate set-up or a blank event
// with starts moves to the run state and loads one descriptor per start (up to 4)
// the cost per item is set by the controller sequence and the single descriptor register
// a stalled descriptor register holds the sequence in its run state
// synchronous reset clears channel enables, pending starts and the output valid;
// channel addresses, counts and modes are not cleared
module dma_channel_descriptor_engine #(
    parameter int CHANNELS     = 4,
    parameter int ADDRESS_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcde_in_if.sink    i_req,
    dcde_out_if.source o_desc
);

    dcde_pkg::t_req    w_req;
    dcde_pkg::t_cmd    w_cmd;
    dcde_pkg::t_status w_status;
    logic              w_ready;

    // request payload
    assign w_req.action         = i_req.action;
    assign w_req.channel        = i_req.channel;
    assign w_req.source_address = i_req.source_address;
    assign w_req.dest_address   = i_req.dest_address;
    assign w_req.control_word   = i_req.control_word;
    assign i_req.ready          = w_ready;

    // sequencer
    dcde_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .o_ready  (w_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // channel state and descriptor datapath
    dcde_datapath #(
        .CHANNELS     (CHANNELS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_desc   (o_desc)
    );

endmodule
